// File: hw/rtl/kcd_pkg.sv
package kcd_pkg;

    localparam int KEY_COUNT  = 4;
    localparam int TIME_WIDTH = 32;
    localparam int DT_WIDTH   = 16;
    localparam int CODE_WIDTH = 4;

    typedef logic [KEY_COUNT-1:0]  t_keys;
    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [DT_WIDTH-1:0]   t_dt;
    typedef logic [CODE_WIDTH-1:0] t_code;

    // event codes
    localparam t_code CODE_NONE  = 4'd0;
    localparam t_code CODE_K1    = 4'd1;
    localparam t_code CODE_K2    = 4'd2;
    localparam t_code CODE_K3    = 4'd3;
    localparam t_code CODE_K4    = 4'd4;
    localparam t_code CODE_K12   = 4'd5;
    localparam t_code CODE_K13   = 4'd6;
    localparam t_code CODE_K23   = 4'd7;
    localparam t_code CODE_ALL   = 4'd8;
    localparam t_code CODE_K34   = 4'd9;
    localparam t_code CODE_K14   = 4'd10;

    // key masks
    localparam t_keys MASK_K1  = 4'h1;
    localparam t_keys MASK_K2  = 4'h2;
    localparam t_keys MASK_K3  = 4'h4;
    localparam t_keys MASK_K4  = 4'h8;
    localparam t_keys MASK_K12 = 4'h3;
    localparam t_keys MASK_K13 = 4'h5;
    localparam t_keys MASK_K23 = 4'h6;
    localparam t_keys MASK_K34 = 4'hC;
    localparam t_keys MASK_K14 = 4'h9;
    localparam t_keys MASK_ALL = 4'hF;

    function automatic t_code kcd_code_for_mask(input t_keys mask);
        t_code code;
        case (mask)
            MASK_ALL: code = CODE_ALL;
            MASK_K12: code = CODE_K12;
            MASK_K13: code = CODE_K13;
            MASK_K23: code = CODE_K23;
            MASK_K14: code = CODE_K14;
            MASK_K34: code = CODE_K34;
            MASK_K1:  code = CODE_K1;
            MASK_K2:  code = CODE_K2;
            MASK_K3:  code = CODE_K3;
            MASK_K4:  code = CODE_K4;
            default:  code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/key_chord_debouncer_core.sv
// key chord debouncer
// input channel: i_in_valid / o_in_stall carry one word of four raw key
//   levels (i_raw_keys) and a millisecond timestamp (i_now_time)
// output channel: o_out_valid / i_out_stall carry one word per input word:
//   o_event_code (new chord or key code, 0 when nothing new) and
//   o_stable_keys (debounced levels after that sample)
// config channel: i_cfg_valid / o_cfg_ready write debounce_time; ready is
//   always high, write only while the block is idle
// path: an accepted word passes through the input register, then the
//   per-key subtract/compare and code lookup into the output register
// throughput: one word per cycle while the output is not stalled; the key
//   state is updated as a word moves from the input register to the output
//   register, so the next word already sees it
// stall: when the output register is full and stalled, the word in the
//   input register waits and o_in_stall rises; the output word holds
// reset: synchronous active low; clears key state, reported code, the
//   debounce time and both valid flags
module key_chord_debouncer_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  kcd_pkg::t_keys         i_raw_keys,
    input  kcd_pkg::t_time         i_now_time,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output kcd_pkg::t_code         o_event_code,
    output kcd_pkg::t_keys         o_stable_keys,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  kcd_pkg::t_dt           i_cfg_debounce_time
);
    import kcd_pkg::*;

    // input register
    logic  r_in_valid;
    t_keys r_in_raw;
    t_time r_in_time;

    // output register
    logic  r_out_valid;
    t_code r_out_code;
    t_keys r_out_keys;

    // key state
    t_dt   r_debounce_time;
    t_keys r_prev_raw;
    t_keys r_debounced;
    t_time r_change_time [KEY_COUNT];
    t_code r_reported_code;

    t_keys n_debounced;
    t_time n_change_time [KEY_COUNT];
    t_code n_reported_code;
    t_code n_event;
    t_code mask_code;
    t_time held [KEY_COUNT];

    logic out_free;
    logic fire;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_event_code  = r_out_code;
    assign o_stable_keys = r_out_keys;

    // per-key timing, all keys in parallel
    always_comb begin
        n_debounced = r_debounced;
        for (int i = 0; i < KEY_COUNT; i++) begin
            // a raw edge restarts the hold timer
            n_change_time[i] = (r_in_raw[i] != r_prev_raw[i]) ? r_in_time
                                                               : r_change_time[i];
            held[i] = r_in_time - n_change_time[i];
            if (r_in_raw[i] != r_debounced[i]) begin
                if (r_debounce_time == '0 ||
                    held[i] >= TIME_WIDTH'(r_debounce_time)) begin
                    n_debounced[i] = r_in_raw[i];
                end
            end
        end
    end

    // chord lookup and repeat suppression
    always_comb begin
        mask_code       = kcd_code_for_mask(n_debounced);
        n_event         = CODE_NONE;
        n_reported_code = r_reported_code;
        if (mask_code != CODE_NONE) begin
            if (mask_code != r_reported_code) begin
                n_reported_code = mask_code;
                n_event         = mask_code;
            end
        end else begin
            n_reported_code = CODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_debounce_time <= '0;
            r_prev_raw      <= '0;
            r_debounced     <= '0;
            r_reported_code <= CODE_NONE;
            for (int i = 0; i < KEY_COUNT; i++) begin
                r_change_time[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_debounce_time <= i_cfg_debounce_time;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid     <= 1'b1;
                r_prev_raw      <= r_in_raw;
                r_debounced     <= n_debounced;
                r_reported_code <= n_reported_code;
                for (int i = 0; i < KEY_COUNT; i++) begin
                    r_change_time[i] <= n_change_time[i];
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_raw  <= i_raw_keys;
            r_in_time <= i_now_time;
        end
        if (fire) begin
            r_out_code <= n_event;
            r_out_keys <= n_debounced;
        end
    end

endmodule

// File: hw/rtl/kcd_checker.sv
module kcd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input kcd_pkg::t_code o_event_code,
    input kcd_pkg::t_keys o_stable_keys
);
    import kcd_pkg::*;

    // held output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_event_code) && $stable(o_stable_keys))
        else $error("stalled output word changed");

    // a reported event always matches the debounced mask shown with it
    a_event_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_code != CODE_NONE |->
            o_event_code == kcd_code_for_mask(o_stable_keys))
        else $error("event code does not match stable keys");

    // upstream is stalled only while the output is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a full output");

    // an accepted word reaches the output register when the output is not blocked
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted word did not reach the output");

endmodule

bind key_chord_debouncer_core kcd_checker u_kcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_event_code  (o_event_code),
    .o_stable_keys (o_stable_keys)
);
